### hw/rtl/spm_pkg.sv
// Shared types and constants of the slotted page record manager.
package spm_pkg;

	localparam int HEADER_BYTES = 64;
	localparam int SLOT_BYTES   = 4;
	localparam int KIND_W       = 2;
	localparam int SLOT_W       = 10;
	localparam int BIDX_W       = 12;
	localparam int DATA_W       = 8;
	localparam int STATUS_W     = 3;
	localparam int LEN_W        = 12;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ   = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_ERASE  = 2'd2,
		KIND_UPDATE = 2'd3
	} spm_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 3'd0,
		STS_SLOT  = 3'd1,
		STS_SIZE  = 3'd2,
		STS_FULL  = 3'd3,
		STS_FIT   = 3'd4,
		STS_INDEX = 3'd5
	} spm_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_WT,
		S_RD_DATA,
		S_ER_WT,
		S_SRCH,
		S_SRCH_WT,
		S_CHK,
		S_UP_WT,
		S_RP_RD,
		S_RP_WT,
		S_RP_BACK,
		S_PLACE,
		S_COPY,
		S_DONE,
		S_RES
	} spm_state_t;

	typedef enum logic [1:0] {
		SRC_HEAP,
		SRC_SCRATCH,
		SRC_STAGE
	} spm_src_t;

	typedef struct packed {
		spm_kind_t          kind;
		logic [SLOT_W-1:0]  slot;
		logic [BIDX_W-1:0]  byte_index;
		logic [DATA_W-1:0]  data_byte;
		logic               last;
		logic               yields;
	} spm_item_t;

	typedef struct packed {
		logic      valid;
		spm_item_t item;
	} spm_head_t;

endpackage

### hw/rtl/slotted_page_record_manager.sv
// Top level of the slotted page record manager.
// The input channel (in_valid, in_stall) takes one word per accepted edge:
// kind, slot, byte_index, data_byte and last. Insert and update words carry
// one record byte each; the word with last set runs the operation. Read and
// erase words, and the last byte of an insert or update, give one result on
// the output channel (out_valid, out_stall). Other record bytes give none.
// Words enter a four-entry queue, so up to four words are taken while the
// back end is busy or a result waits. An insert walks the directory to find
// a free entry, then copies the record at one byte a cycle; an update, and an
// insert that finds too small a gap, first repack the page, copying every live
// record into a scratch buffer and then back to the top of the heap.
// Reset empties the page and the queue. A stalled result holds in the output
// register; the back end starts no further result until it is taken, and the
// input stalls once the queue is full.
module slotted_page_record_manager import spm_pkg::*; #(
	parameter int PAGE_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [BIDX_W-1:0]   byte_index,
	input  logic [DATA_W-1:0]   data_byte,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot_out,
	output logic [DATA_W-1:0]   read_byte,
	output logic [LEN_W-1:0]    record_length,
	output logic [LEN_W-1:0]    free_space
);

	spm_head_t head;
	logic      pop;

	spm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.slot       (slot),
		.byte_index (byte_index),
		.data_byte  (data_byte),
		.last       (last),
		.head       (head),
		.pop        (pop)
	);

	spm_back #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.slot_out      (slot_out),
		.read_byte     (read_byte),
		.record_length (record_length),
		.free_space    (free_space)
	);

endmodule

### hw/rtl/spm_front.sv
// Front part: accepts words, classifies them and queues them for the back part.
module spm_front import spm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [BIDX_W-1:0]   byte_index,
	input  logic [DATA_W-1:0]   data_byte,
	input  logic                last,
	output spm_head_t           head,
	input  logic                pop
);

	spm_item_t          fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push;
	spm_item_t          item_in;

	assign in_stall = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign push     = in_valid && !in_stall;

	always_comb begin
		item_in.kind       = spm_kind_t'(kind);
		item_in.slot       = slot;
		item_in.byte_index = byte_index;
		item_in.data_byte  = data_byte;
		item_in.last       = last;
		item_in.yields     = !(((kind == KIND_INSERT) || (kind == KIND_UPDATE)) && !last);
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/spm_back.sv
// Back part: page store, slot directory, compaction and result register.
module spm_back import spm_pkg::*; #(
	parameter int PAGE_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spm_head_t           head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot_out,
	output logic [DATA_W-1:0]   read_byte,
	output logic [LEN_W-1:0]    record_length,
	output logic [LEN_W-1:0]    free_space
);

	localparam int AW         = $clog2(PAGE_BYTES);
	localparam int CW         = AW + 1;
	localparam int MAX_SLOTS  = (PAGE_BYTES - HEADER_BYTES) / SLOT_BYTES;
	localparam int MAX_RECORD = PAGE_BYTES - HEADER_BYTES - SLOT_BYTES;
	localparam int SW         = $clog2(MAX_SLOTS);
	localparam int NW         = $clog2(MAX_SLOTS + 1);
	localparam int PW         = ((CW > BIDX_W) ? CW : BIDX_W) + 1;

	logic [DATA_W-1:0] heap_mem    [PAGE_BYTES];
	logic [DATA_W-1:0] scratch_mem [PAGE_BYTES];
	logic [DATA_W-1:0] stg_mem     [PAGE_BYTES];
	logic [2*CW-1:0]   dir_mem     [MAX_SLOTS];

	spm_state_t          state_q, state_d, cp_ret_q;
	spm_src_t            cp_src_q;
	logic [NW-1:0]       slot_count_q, idx_q, tgt_q;
	logic [CW-1:0]       heap_top_q, bytes_q, stg_cnt_q, upper_q, size_q;
	logic                grow_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [BIDX_W-1:0]   bidx_q;
	logic [STATUS_W-1:0] r_status_q;
	logic [SLOT_W-1:0]   r_slot_q;
	logic [DATA_W-1:0]   r_byte_q;
	logic [CW-1:0]       r_len_q;
	logic [AW-1:0]       cp_sbase_q, cp_dbase_q;
	logic [CW-1:0]       cp_len_q, cp_k_q;
	logic                cp_pend_s1;
	logic [AW-1:0]       cp_waddr_s1;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [DATA_W-1:0]   out_byte_q;
	logic [LEN_W-1:0]    out_len_q, out_free_q;

	logic [DATA_W-1:0] heap_rdata, scratch_rdata, stg_rdata;
	logic [2*CW-1:0]   dir_rdata;
	logic [CW-1:0]     dir_off, dir_len;
	logic [CW-1:0]     free_w, new_size, need, dir_end, clen, unew, place_at;
	logic              take, is_stage, stg_full, range_bad, size_bad;
	logic              idx_bad, pos_bad, full, gap_short, fit_bad, cp_done, cp_issue;
	logic [PW-1:0]     rd_pos;
	logic [AW-1:0]     cp_raddr, heap_raddr;
	logic              stg_we, dir_we, heap_we, scratch_we;
	logic [SW-1:0]     dir_raddr, dir_waddr;
	logic [2*CW-1:0]   dir_wdata;
	logic [DATA_W-1:0] heap_wdata;

	assign dir_off  = dir_rdata[2*CW-1:CW];
	assign dir_len  = dir_rdata[CW-1:0];
	assign free_w   = CW'(PAGE_BYTES - HEADER_BYTES) - (CW'(slot_count_q) << 2) - bytes_q;
	assign stg_full = (stg_cnt_q == CW'(PAGE_BYTES));
	assign new_size = stg_full ? stg_cnt_q : stg_cnt_q + 1'b1;
	assign is_stage = (head.item.kind == KIND_INSERT) || (head.item.kind == KIND_UPDATE);
	assign take     = (state_q == S_IDLE) && head.valid && (!head.item.yields || !out_valid_q);
	assign pop      = take;
	assign range_bad = (NW+SLOT_W)'(head.item.slot) >= (NW+SLOT_W)'(slot_count_q);
	assign size_bad  = (new_size == '0) || (new_size > CW'(MAX_RECORD));
	assign idx_bad   = PW'(bidx_q) >= PW'(dir_len);
	assign rd_pos    = PW'(dir_off) + PW'(bidx_q);
	assign pos_bad   = rd_pos >= PW'(PAGE_BYTES);
	assign need      = size_q + (grow_q ? CW'(SLOT_BYTES) : '0);
	assign dir_end   = CW'(HEADER_BYTES) + (CW'(slot_count_q) << 2);
	assign full      = (free_w < need) || (grow_q && (tgt_q >= NW'(MAX_SLOTS)));
	assign gap_short = (heap_top_q < dir_end) || ((heap_top_q - dir_end) < need);
	assign fit_bad   = ((CW+1)'(free_w) + (CW+1)'(dir_len)) < (CW+1)'(size_q);
	assign clen      = (dir_len > upper_q) ? upper_q : dir_len;
	assign unew      = upper_q - clen;
	assign place_at  = heap_top_q - size_q;
	assign cp_issue  = cp_k_q < cp_len_q;
	assign cp_done   = !cp_issue && !cp_pend_s1;
	assign cp_raddr  = cp_sbase_q + cp_k_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (head.item.kind)
						KIND_READ:   state_d = range_bad ? S_RES : S_RD_WT;
						KIND_ERASE:  state_d = range_bad ? S_RES : S_ER_WT;
						KIND_INSERT: begin
							if (head.item.last) begin
								state_d = size_bad ? S_RES : S_SRCH;
							end
						end
						default: begin
							if (head.item.last) begin
								state_d = range_bad ? S_RES : S_UP_WT;
							end
						end
					endcase
				end
			end
			S_RD_WT:   state_d = (idx_bad || pos_bad) ? S_RES : S_RD_DATA;
			S_RD_DATA: state_d = S_RES;
			S_ER_WT:   state_d = S_RES;
			S_SRCH:    state_d = (idx_q < slot_count_q) ? S_SRCH_WT : S_CHK;
			S_SRCH_WT: state_d = (dir_len == '0) ? S_CHK : S_SRCH;
			S_CHK: begin
				if (full) begin
					state_d = S_RES;
				end else begin
					state_d = gap_short ? S_RP_RD : S_PLACE;
				end
			end
			S_UP_WT:   state_d = fit_bad ? S_RES : S_RP_RD;
			S_RP_RD:   state_d = (idx_q < slot_count_q) ? S_RP_WT : S_RP_BACK;
			S_RP_WT:   state_d = S_COPY;
			S_RP_BACK: state_d = S_COPY;
			S_PLACE:   state_d = S_COPY;
			S_COPY:    state_d = cp_done ? cp_ret_q : S_COPY;
			S_DONE:    state_d = S_RES;
			S_RES:     state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		stg_we     = take && is_stage && !stg_full;
		dir_raddr  = idx_q[SW-1:0];
		dir_we     = 1'b0;
		dir_waddr  = SW'(slot_q);
		dir_wdata  = {dir_off, CW'(0)};
		heap_raddr = cp_raddr;
		heap_we    = cp_pend_s1 && (cp_src_q != SRC_HEAP);
		scratch_we = cp_pend_s1 && (cp_src_q == SRC_HEAP);
		heap_wdata = (cp_src_q == SRC_SCRATCH) ? scratch_rdata : stg_rdata;
		case (state_q)
			S_IDLE:  dir_raddr = SW'(head.item.slot);
			S_RD_WT: heap_raddr = rd_pos[AW-1:0];
			S_ER_WT: dir_we = 1'b1;
			S_UP_WT: dir_we = !fit_bad;
			S_RP_WT: begin
				dir_we    = 1'b1;
				dir_waddr = idx_q[SW-1:0];
				dir_wdata = {unew, dir_len};
			end
			S_PLACE: begin
				dir_we    = 1'b1;
				dir_waddr = tgt_q[SW-1:0];
				dir_wdata = {place_at, size_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		heap_rdata    <= heap_mem[heap_raddr];
		scratch_rdata <= scratch_mem[cp_raddr];
		stg_rdata     <= stg_mem[cp_raddr];
		dir_rdata     <= dir_mem[dir_raddr];
		if (heap_we) begin
			heap_mem[cp_waddr_s1] <= heap_wdata;
		end
		if (scratch_we) begin
			scratch_mem[cp_waddr_s1] <= heap_rdata;
		end
		if (stg_we) begin
			stg_mem[stg_cnt_q[AW-1:0]] <= head.item.data_byte;
		end
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cp_ret_q     <= S_IDLE;
			cp_src_q     <= SRC_HEAP;
			slot_count_q <= '0;
			idx_q        <= '0;
			tgt_q        <= '0;
			heap_top_q   <= CW'(PAGE_BYTES);
			bytes_q      <= '0;
			stg_cnt_q    <= '0;
			upper_q      <= '0;
			size_q       <= '0;
			grow_q       <= 1'b0;
			slot_q       <= '0;
			bidx_q       <= '0;
			r_status_q   <= '0;
			r_slot_q     <= '0;
			r_byte_q     <= '0;
			r_len_q      <= '0;
			cp_sbase_q   <= '0;
			cp_dbase_q   <= '0;
			cp_len_q     <= '0;
			cp_k_q       <= '0;
			cp_pend_s1   <= 1'b0;
			cp_waddr_s1  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_slot_q   <= '0;
			out_byte_q   <= '0;
			out_len_q    <= '0;
			out_free_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						slot_q     <= head.item.slot;
						bidx_q     <= head.item.byte_index;
						tgt_q      <= NW'(head.item.slot);
						grow_q     <= 1'b0;
						idx_q      <= '0;
						r_status_q <= STS_OK;
						r_slot_q   <= head.item.slot;
						r_byte_q   <= '0;
						r_len_q    <= '0;
						if (is_stage) begin
							size_q    <= new_size;
							stg_cnt_q <= head.item.last ? CW'(0) : new_size;
							if (head.item.kind == KIND_INSERT) begin
								r_slot_q <= '0;
								if (size_bad) begin
									r_status_q <= STS_SIZE;
								end
							end else if (range_bad) begin
								r_status_q <= STS_SLOT;
							end
						end else if (range_bad) begin
							r_status_q <= STS_SLOT;
						end
					end
				end
				S_RD_WT: begin
					r_len_q <= dir_len;
					if (idx_bad) begin
						r_status_q <= STS_INDEX;
					end
				end
				S_RD_DATA: r_byte_q <= heap_rdata;
				S_ER_WT:   bytes_q <= bytes_q - dir_len;
				S_SRCH: begin
					if (!(idx_q < slot_count_q)) begin
						tgt_q  <= idx_q;
						grow_q <= 1'b1;
					end
				end
				S_SRCH_WT: begin
					if (dir_len == '0) begin
						tgt_q <= idx_q;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_CHK: begin
					idx_q   <= '0;
					upper_q <= CW'(PAGE_BYTES);
					if (full) begin
						r_status_q <= STS_FULL;
					end
				end
				S_UP_WT: begin
					idx_q   <= '0;
					upper_q <= CW'(PAGE_BYTES);
					if (fit_bad) begin
						r_status_q <= STS_FIT;
						r_len_q    <= dir_len;
					end else begin
						bytes_q <= bytes_q - dir_len;
					end
				end
				S_RP_WT: begin
					upper_q    <= unew;
					idx_q      <= idx_q + 1'b1;
					cp_src_q   <= SRC_HEAP;
					cp_sbase_q <= dir_off[AW-1:0];
					cp_dbase_q <= unew[AW-1:0];
					cp_len_q   <= clen;
					cp_k_q     <= '0;
					cp_ret_q   <= S_RP_RD;
				end
				S_RP_BACK: begin
					heap_top_q <= upper_q;
					cp_src_q   <= SRC_SCRATCH;
					cp_sbase_q <= upper_q[AW-1:0];
					cp_dbase_q <= upper_q[AW-1:0];
					cp_len_q   <= CW'(PAGE_BYTES) - upper_q;
					cp_k_q     <= '0;
					cp_ret_q   <= S_PLACE;
				end
				S_PLACE: begin
					if (grow_q) begin
						slot_count_q <= slot_count_q + 1'b1;
					end
					heap_top_q <= place_at;
					bytes_q    <= bytes_q + size_q;
					cp_src_q   <= SRC_STAGE;
					cp_sbase_q <= '0;
					cp_dbase_q <= place_at[AW-1:0];
					cp_len_q   <= size_q;
					cp_k_q     <= '0;
					cp_ret_q   <= S_DONE;
				end
				S_COPY: begin
					cp_pend_s1  <= cp_issue;
					cp_waddr_s1 <= cp_dbase_q + cp_k_q[AW-1:0];
					if (cp_issue) begin
						cp_k_q <= cp_k_q + 1'b1;
					end
				end
				S_DONE: begin
					r_slot_q <= SLOT_W'(tgt_q);
					r_len_q  <= size_q;
				end
				S_RES: begin
					out_valid_q  <= 1'b1;
					out_status_q <= r_status_q;
					out_slot_q   <= r_slot_q;
					out_byte_q   <= r_byte_q;
					out_len_q    <= LEN_W'(r_len_q);
					out_free_q   <= LEN_W'(free_w);
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign slot_out      = out_slot_q;
	assign read_byte     = out_byte_q;
	assign record_length = out_len_q;
	assign free_space    = out_free_q;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the slotted page record manager with its own page predictor.
module testbench;
	import spm_pkg::*;

	localparam int PAGE = 4096;
	localparam int MAX_SLOTS = (PAGE - HEADER_BYTES) / SLOT_BYTES;
	localparam int MAX_REC = PAGE - HEADER_BYTES - SLOT_BYTES;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		spm_status_t sts;
		int          slot_no;
		int          rbyte;
		int          rlen;
		int          space_left;
	} page_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [KIND_W-1:0]   kind;
	logic [SLOT_W-1:0]   slot;
	logic [BIDX_W-1:0]   byte_index;
	logic [DATA_W-1:0]   data_byte;
	logic                last;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_out;
	logic [DATA_W-1:0]   read_byte;
	logic [LEN_W-1:0]    record_length;
	logic [LEN_W-1:0]    free_space;

	slotted_page_record_manager uut (.*);

	// Predicted page contents.
	byte unsigned heap_mem[PAGE];
	byte unsigned repack_buf[PAGE];
	byte unsigned stage_mem[PAGE];
	int dir_off[MAX_SLOTS];
	int dir_len[MAX_SLOTS];
	int live_slots;
	int heap_top;
	int live_bytes;
	int stage_len;

	page_result_t expected_results[$];
	int errors;
	int words_sent;
	int cycles;
	bit no_idle;
	bit hold_req;
	int hold_cnt;
	int stall_run;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int page_free();
		return PAGE - HEADER_BYTES - SLOT_BYTES * live_slots - live_bytes;
	endfunction

	function automatic void repack_page();
		int upper;
		int n;
		upper = PAGE;
		for (int i = 0; i < live_slots; i++) begin
			n = dir_len[i];
			if (n > upper)
				n = upper;
			upper -= n;
			for (int j = 0; j < n; j++)
				repack_buf[upper + j] = heap_mem[dir_off[i] + j];
			dir_off[i] = upper;
		end
		for (int j = upper; j < PAGE; j++)
			heap_mem[j] = repack_buf[j];
		heap_top = upper;
	endfunction

	function automatic void place_record(int s, int size);
		int upper;
		upper = heap_top - size;
		for (int j = 0; j < size; j++)
			heap_mem[upper + j] = stage_mem[j];
		dir_off[s] = upper;
		dir_len[s] = size;
		heap_top = upper;
		live_bytes += size;
	endfunction

	// Applies one accepted word to the page prediction; returns 1 when a result follows.
	function automatic bit predict_page(spm_kind_t k, int s, int bidx, int d, bit lst,
			output page_result_t res);
		int size;
		int fs;
		int need;
		int old;
		bit grow;
		res.sts = STS_OK;
		res.slot_no = 0;
		res.rbyte = 0;
		res.rlen = 0;
		if (k == KIND_INSERT || k == KIND_UPDATE) begin
			if (stage_len < PAGE) begin
				stage_mem[stage_len] = d;
				stage_len++;
			end
			if (!lst)
				return 0;
			size = stage_len;
			stage_len = 0;
			if (k == KIND_INSERT) begin
				if (size == 0 || size > MAX_REC) begin
					res.sts = STS_SIZE;
				end else begin
					fs = 0;
					while (fs < live_slots && dir_len[fs] != 0)
						fs++;
					grow = (fs == live_slots);
					need = size + (grow ? SLOT_BYTES : 0);
					if (page_free() < need || (grow && fs >= MAX_SLOTS)) begin
						res.sts = STS_FULL;
					end else begin
						if (heap_top < HEADER_BYTES + SLOT_BYTES * live_slots
								|| heap_top - (HEADER_BYTES + SLOT_BYTES * live_slots) < need)
							repack_page();
						if (grow)
							live_slots++;
						place_record(fs, size);
						res.slot_no = fs;
						res.rlen = size;
					end
				end
			end else begin
				res.slot_no = s;
				if (s >= live_slots) begin
					res.sts = STS_SLOT;
				end else begin
					old = dir_len[s];
					if (page_free() + old < size) begin
						res.sts = STS_FIT;
						res.rlen = old;
					end else begin
						live_bytes -= old;
						dir_len[s] = 0;
						repack_page();
						place_record(s, size);
						res.rlen = size;
					end
				end
			end
		end else if (k == KIND_ERASE) begin
			res.slot_no = s;
			if (s >= live_slots) begin
				res.sts = STS_SLOT;
			end else begin
				live_bytes -= dir_len[s];
				dir_len[s] = 0;
			end
		end else begin
			res.slot_no = s;
			if (s >= live_slots) begin
				res.sts = STS_SLOT;
			end else begin
				res.rlen = dir_len[s];
				if (bidx >= res.rlen)
					res.sts = STS_INDEX;
				else if (dir_off[s] + bidx < PAGE)
					res.rbyte = heap_mem[dir_off[s] + bidx];
			end
		end
		res.space_left = page_free();
		return 1;
	endfunction

	task automatic send_word(spm_kind_t k, int s, int bidx, int d, bit lst);
		page_result_t res;
		int n;
		kind <= k;
		slot <= s;
		byte_index <= bidx;
		data_byte <= d;
		last <= lst;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
		if (predict_page(k, s, bidx, d, lst, res))
			expected_results.push_back(res);
		n = no_idle ? 0 : gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_record(spm_kind_t k, int s, int len);
		for (int i = 0; i < len; i++)
			send_word(k, (i == len - 1) ? s : $urandom_range(0, 1023),
				$urandom_range(0, 4095), $urandom_range(0, 255), i == len - 1);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Result checker.
	always @(posedge clk) begin
		page_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: status %0d slot %0d", $time,
					status, slot_out);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.sts) begin
					$display("%0t: status expected %0d actual %0d", $time, e.sts, status);
					errors++;
				end
				if (slot_out !== e.slot_no[SLOT_W-1:0]) begin
					$display("%0t: slot_out expected %0d actual %0d", $time, e.slot_no,
						slot_out);
					errors++;
				end
				if (read_byte !== e.rbyte[DATA_W-1:0]) begin
					$display("%0t: read_byte expected %0d actual %0d", $time, e.rbyte,
						read_byte);
					errors++;
				end
				if (record_length !== e.rlen[LEN_W-1:0]) begin
					$display("%0t: record_length expected %0d actual %0d", $time, e.rlen,
						record_length);
					errors++;
				end
				if (free_space !== e.space_left[LEN_W-1:0]) begin
					$display("%0t: free_space expected %0d actual %0d", $time, e.space_left,
						free_space);
					errors++;
				end
			end
		end
	end

	// Receiver stall pattern, with a long hold-off on request.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_cnt = 400;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!no_idle && $urandom_range(0, 99) < 25)
				stall_run = gap_len();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("slotted_page_record_manager: mismatch");
			$finish;
		end
	end

	task automatic test_edge_records();
		send_word(KIND_READ, 0, 0, 0, 1'b0);
		send_record(KIND_INSERT, 0, 400);
		send_record(KIND_INSERT, 0, 1);
		send_record(KIND_UPDATE, 0, 150);
		send_word(KIND_READ, 0, 149, 0, 1'b0);
		send_word(KIND_READ, 0, 150, 0, 1'b0);
		send_word(KIND_READ, 0, 4095, 0, 1'b0);
		send_word(KIND_ERASE, 0, 0, 0, 1'b0);
		send_word(KIND_ERASE, 1023, 0, 0, 1'b0);
		send_word(KIND_READ, 0, 0, 0, 1'b0);
		send_record(KIND_UPDATE, 1007, 2);
		send_word(KIND_INSERT, 0, 0, 8'hff, 1'b0);
		send_word(KIND_INSERT, 0, 0, 8'h00, 1'b1);
	endtask

	task automatic test_mixed_stream();
		send_record(KIND_INSERT, 0, 5);
		send_record(KIND_INSERT, 0, 7);
		send_word(KIND_INSERT, 0, 0, 8'h5a, 1'b0);
		send_word(KIND_READ, 1, 3, 0, 1'b0);
		send_word(KIND_INSERT, 0, 0, 8'ha5, 1'b0);
		send_word(KIND_ERASE, 5, 0, 0, 1'b0);
		send_word(KIND_UPDATE, 1, 0, 8'h3c, 1'b1);
		send_word(KIND_READ, 1, 2, 0, 1'b0);
		send_word(KIND_ERASE, 0, 0, 0, 1'b0);
		send_record(KIND_INSERT, 0, 4);
		send_record(KIND_UPDATE, 2, 9);
		send_word(KIND_READ, 2, 8, 0, 1'b0);
	endtask

	task automatic test_backpressure();
		wait_drain();
		hold_req = 1;
		for (int i = 0; i < 30; i++)
			send_word(KIND_READ, $urandom_range(0, live_slots), $urandom_range(0, 6), 0,
				1'b0);
	endtask

	task automatic test_random_traffic(int n_words);
		int r;
		int s;
		int stop_at;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 49) == 0)
				no_idle = ~no_idle;
			r = $urandom_range(0, 99);
			s = $urandom_range(0, live_slots > 0 ? live_slots - 1 : 0);
			if (live_bytes > 500 && r < 40)
				r = 60;
			if (r < 35) begin
				send_record(KIND_INSERT, 0, ($urandom_range(0, 19) == 0) ?
					$urandom_range(40, 200) : $urandom_range(1, 10));
			end else if (r < 55) begin
				send_word(KIND_READ, s, (dir_len[s] > 0 && $urandom_range(0, 3) != 0) ?
					$urandom_range(0, dir_len[s] - 1) : $urandom_range(0, 4095), 0, 1'b0);
			end else if (r < 75) begin
				send_word(KIND_ERASE, s, $urandom_range(0, 4095), $urandom_range(0, 255),
					1'b0);
			end else if (r < 85) begin
				send_record(KIND_UPDATE, s, $urandom_range(1, 10));
			end else if (r < 93) begin
				send_word(spm_kind_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
					$urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 1));
			end else begin
				send_word(KIND_INSERT, 0, 0, $urandom_range(0, 255), 1'b0);
				send_word(KIND_READ, s, $urandom_range(0, 3), 0, 1'b0);
				send_word(($urandom_range(0, 1) == 1) ? KIND_UPDATE : KIND_INSERT, s, 0,
					$urandom_range(0, 255), 1'b1);
			end
		end
		no_idle = 0;
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		kind = KIND_READ;
		slot = 0;
		byte_index = 0;
		data_byte = 0;
		last = 0;
		out_stall = 0;
		errors = 0;
		words_sent = 0;
		cycles = 0;
		no_idle = 0;
		hold_req = 0;
		hold_cnt = 0;
		stall_run = 0;
		live_slots = 0;
		heap_top = PAGE;
		live_bytes = 0;
		stage_len = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_records();
		test_mixed_stream();
		test_backpressure();
		test_random_traffic(620);
		wait_drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("slotted_page_record_manager: match");
		else
			$display("slotted_page_record_manager: mismatch");
		$finish;
	end

endmodule
